// File: hdl/ffha_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes for the first-fit heap allocator
// no dependencies

package ffha_pkg;

    localparam int ARENA_BYTES    = 65536;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEADER_BYTES   = 32;
    localparam int ALIGN_BYTES    = 16;
    localparam int CHUNK_RESET    = 3 * 4096;

    localparam int ADDR_W     = 17;
    localparam int SUM_W      = 18;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    localparam logic [SUM_W-1:0]  HDR        = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]  ARENA_S    = SUM_W'(ARENA_BYTES);
    localparam logic [SUM_W-1:0]  SPLIT_MIN  = SUM_W'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [SUM_W-1:0]  ALIGN_LOW  = SUM_W'(ALIGN_BYTES - 1);
    localparam logic [SUM_W-1:0]  ALIGN_MASK = ~SUM_W'(ALIGN_BYTES - 1);
    localparam logic [ADDR_W-1:0] CHUNK_RST  = ADDR_W'(CHUNK_RESET);
    localparam logic [ADDR_W-1:0] LIMIT_RST  = ADDR_W'(ARENA_BYTES);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_OOM  = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic {
        CFG_CHUNK = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_idx_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t               op;
        logic              zero;
        logic [SUM_W-1:0]  aligned;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    // one descriptor of the block table
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              used;
    } desc_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_ALLOC_DEC,
        S_GROW_DEC,
        S_FREE_DEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIN0,
        S_FIN1,
        S_RESP
    } state_t;

endpackage

// File: hdl/ffha_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ffha_front.sv
`timescale 1ns / 1ps
// front end: takes request words, classifies them and queues them for the back end
// depends on ffha_pkg

module ffha_front import ffha_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output cmd_t                 q_cmd
);

    cmd_t        slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        cls;
    logic        push, pop;
    logic [SUM_W-1:0] size_ext;

    // classify the request word: opcode, zero-size flag, size rounded up to the alignment, address
    always_comb begin
        size_ext    = {1'b0, s_tdata[ADDR_W-1:0]};
        cls.op      = op_t'(s_tuser);
        cls.zero    = (s_tdata[ADDR_W-1:0] == '0);
        cls.aligned = (size_ext + ALIGN_LOW) & ALIGN_MASK;
        cls.addr    = s_tdata[2*ADDR_W-1:ADDR_W];
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = slot_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= cls;
        end
    end

endmodule

// File: hdl/ffha_back.sv
`timescale 1ns / 1ps
// back end: walks the descriptor table, splits, grows, merges and shifts entries
// depends on ffha_pkg and ffha_ram

module ffha_back import ffha_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  cfg_idx_t          cfg_index,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_t              q_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic [ADDR_W-1:0] out_addr,
    output logic              out_released
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int DW = $bits(desc_t);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     idx_reg, idx_next;
    desc_t             cur_reg, cur_next;
    desc_t             prev_reg, prev_next;
    desc_t             nxt_reg, nxt_next;
    logic              has_next_reg, has_next_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0] brk_reg, brk_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [ADDR_W-1:0] chunk_reg, chunk_next;
    logic [ADDR_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]     src_reg, src_next;
    logic [CW-1:0]     stop_reg, stop_next;
    logic [CW-1:0]     dist_reg, dist_next;
    logic              up_reg, up_next;
    logic [CW-1:0]     f0a_reg, f0a_next;
    desc_t             f0d_reg, f0d_next;
    logic [CW-1:0]     f1a_reg, f1a_next;
    desc_t             f1d_reg, f1d_next;
    logic              two_reg, two_next;
    status_t           rst_reg, rst_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic              rrel_reg, rrel_next;
    logic              ov_reg, ov_next;
    status_t           os_reg, os_next;
    logic [ADDR_W-1:0] oa_reg, oa_next;
    logic              orl_reg, orl_next;

    logic              ram_we;
    logic [CW-1:0]     ram_wa, ram_ra;
    desc_t             ram_wd;
    logic [DW-1:0]     ram_rdata;
    desc_t             rd;

    // decision flags
    logic [SUM_W-1:0]  total, grow, lim, chunk_e, g_len;
    logic              is_free, start_null, start_empty, start_range, init_fail;
    logic              hit, last, split_a, oom_g, split_g, mn, mp, released;
    logic [SUM_W-1:0]  len_i;
    logic [1:0]        k;
    logic [CW-1:0]     pos, shift_src;
    logic              shift_done;

    ffha_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa[AW-1:0]),
        .wdata (ram_wd),
        .raddr (ram_ra[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd = desc_t'(ram_rdata);

    always_comb begin
        is_free     = (cmd_reg.op == OP_FREE);
        total       = HDR + cmd_reg.aligned;
        chunk_e     = {1'b0, chunk_reg};
        grow        = (chunk_e > total) ? chunk_e : total;
        lim         = ({1'b0, limit_reg} > ARENA_S) ? ARENA_S : {1'b0, limit_reg};
        g_len       = grow - HDR;
        start_null  = is_free ? (cmd_reg.addr == '0) : cmd_reg.zero;
        start_empty = (count_reg == '0);
        start_range = ({1'b0, cmd_reg.addr} < HDR) || (cmd_reg.addr > brk_reg);
        init_fail   = grow > lim;
        hit = is_free ? ((SUM_W'(rd.start) + HDR) == {1'b0, cmd_reg.addr})
                      : (!rd.used && ({1'b0, rd.len} >= cmd_reg.aligned));
        last        = ((idx_reg + ONE) == count_reg);
        split_a     = (count_reg < MAXC) &&
                      ({1'b0, cur_reg.len} >= cmd_reg.aligned + SPLIT_MIN);
        oom_g       = (count_reg >= MAXC) || ({1'b0, brk_reg} + grow > lim);
        split_g     = ((count_reg + ONE) < MAXC) && (g_len >= cmd_reg.aligned + SPLIT_MIN);
        mn = has_next_reg && !nxt_reg.used &&
             (SUM_W'(cur_reg.start) + HDR + SUM_W'(cur_reg.len) == {1'b0, nxt_reg.start});
        len_i = mn ? (SUM_W'(cur_reg.len) + SUM_W'(nxt_reg.len) + HDR) : SUM_W'(cur_reg.len);
        mp = (idx_reg != '0) && !prev_reg.used &&
             (SUM_W'(prev_reg.start) + HDR + SUM_W'(prev_reg.len) == {1'b0, cur_reg.start});
        released    = (used_reg == ONE);
        k           = 2'(mn) + 2'(mp);
        pos         = mp ? idx_reg : idx_reg + ONE;
        shift_src   = pos + CW'(k);
        shift_done  = (src_reg == stop_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (q_valid) state_next = S_START;
            S_START: begin
                if (start_null) begin
                    state_next = S_RESP;
                end else if (is_free) begin
                    state_next = (start_empty || start_range) ? S_RESP : S_SCAN_RD;
                end else begin
                    state_next = (start_empty && init_fail) ? S_RESP : S_SCAN_RD;
                end
            end
            S_SCAN_RD:   state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (is_free) begin
                    if (hit) begin
                        if (!rd.used) state_next = S_RESP;
                        else state_next = last ? S_FREE_DEC : S_NEXT_RD;
                    end else begin
                        state_next = last ? S_RESP : S_SCAN_RD;
                    end
                end else if (hit) begin
                    state_next = S_ALLOC_DEC;
                end else begin
                    state_next = last ? S_GROW_DEC : S_SCAN_RD;
                end
            end
            S_NEXT_RD:   state_next = S_NEXT_CHK;
            S_NEXT_CHK:  state_next = S_FREE_DEC;
            S_ALLOC_DEC: begin
                state_next = (split_a && (count_reg > idx_reg + ONE)) ? S_SHIFT_RD : S_FIN0;
            end
            S_GROW_DEC:  state_next = oom_g ? S_RESP : S_FIN0;
            S_FREE_DEC: begin
                if (released) state_next = S_RESP;
                else if ((k != 2'd0) && (shift_src < count_reg)) state_next = S_SHIFT_RD;
                else state_next = S_FIN0;
            end
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = shift_done ? S_FIN0 : S_SHIFT_RD;
            S_FIN0:      state_next = two_reg ? S_FIN1 : S_RESP;
            S_FIN1:      state_next = S_RESP;
            S_RESP:      if (!ov_reg || out_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and table port
    always_comb begin
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        has_next_next = has_next_reg;
        count_next    = count_reg;
        brk_next      = brk_reg;
        used_next     = used_reg;
        chunk_next    = chunk_reg;
        limit_next    = limit_reg;
        src_next      = src_reg;
        stop_next     = stop_reg;
        dist_next     = dist_reg;
        up_next       = up_reg;
        f0a_next      = f0a_reg;
        f0d_next      = f0d_reg;
        f1a_next      = f1a_reg;
        f1d_next      = f1d_reg;
        two_next      = two_reg;
        rst_next      = rst_reg;
        raddr_next    = raddr_reg;
        rrel_next     = rrel_reg;
        ov_next       = ov_reg;
        os_next       = os_reg;
        oa_next       = oa_reg;
        orl_next      = orl_reg;
        ram_we        = 1'b0;
        ram_wa        = f0a_reg;
        ram_wd        = f0d_reg;
        ram_ra        = idx_reg;
        q_ready       = (state_reg == S_IDLE);

        if (ov_reg && out_ready) ov_next = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_CHUNK: chunk_next = cfg_wdata;
                CFG_LIMIT: limit_next = cfg_wdata;
                default:   chunk_next = chunk_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid) cmd_next = q_cmd;
            end
            S_START: begin
                rst_next   = ST_OK;
                raddr_next = '0;
                rrel_next  = 1'b0;
                idx_next   = '0;
                if (start_null) begin
                    rst_next = ST_NULL;
                end else if (is_free) begin
                    if (!start_empty && start_range) rst_next = ST_BAD;
                end else if (start_empty) begin
                    if (init_fail) begin
                        rst_next = ST_OOM;
                    end else begin
                        // first growth of an empty heap
                        ram_we     = 1'b1;
                        ram_wa     = '0;
                        ram_wd     = '{start: '0, len: g_len[ADDR_W-1:0], used: 1'b0};
                        count_next = ONE;
                        brk_next   = grow[ADDR_W-1:0];
                    end
                end
            end
            S_SCAN_RD: begin
                ram_ra = idx_reg;
            end
            S_SCAN_CHK: begin
                cur_next      = rd;
                prev_next     = cur_reg;
                has_next_next = !last;
                if (!hit) begin
                    idx_next = idx_reg + ONE;
                    if (is_free && last) rst_next = ST_BAD;
                end else if (is_free && !rd.used) begin
                    rst_next = ST_BAD;
                end
            end
            S_NEXT_RD: begin
                ram_ra = idx_reg + ONE;
            end
            S_NEXT_CHK: begin
                nxt_next = rd;
            end
            S_ALLOC_DEC: begin
                used_next  = used_reg + ONE;
                raddr_next = ADDR_W'(SUM_W'(cur_reg.start) + HDR);
                f0a_next   = idx_reg;
                two_next   = split_a;
                if (split_a) begin
                    f0d_next   = '{start: cur_reg.start,
                                   len: cmd_reg.aligned[ADDR_W-1:0], used: 1'b1};
                    f1a_next   = idx_reg + ONE;
                    f1d_next   = '{start: ADDR_W'(SUM_W'(cur_reg.start) + HDR + cmd_reg.aligned),
                                   len: ADDR_W'(SUM_W'(cur_reg.len) - cmd_reg.aligned - HDR),
                                   used: 1'b0};
                    count_next = count_reg + ONE;
                    // open a hole above the split block
                    up_next    = 1'b1;
                    dist_next  = ONE;
                    src_next   = count_reg - ONE;
                    stop_next  = idx_reg + ONE;
                end else begin
                    f0d_next = '{start: cur_reg.start, len: cur_reg.len, used: 1'b1};
                end
            end
            S_GROW_DEC: begin
                if (oom_g) begin
                    rst_next = ST_OOM;
                end else begin
                    used_next  = used_reg + ONE;
                    raddr_next = ADDR_W'(SUM_W'(brk_reg) + HDR);
                    brk_next   = ADDR_W'(SUM_W'(brk_reg) + grow);
                    f0a_next   = count_reg;
                    f1a_next   = count_reg + ONE;
                    two_next   = split_g;
                    f1d_next   = '{start: ADDR_W'(SUM_W'(brk_reg) + HDR + cmd_reg.aligned),
                                   len: ADDR_W'(g_len - cmd_reg.aligned - HDR), used: 1'b0};
                    if (split_g) begin
                        f0d_next   = '{start: brk_reg, len: cmd_reg.aligned[ADDR_W-1:0],
                                       used: 1'b1};
                        count_next = count_reg + CW'(2);
                    end else begin
                        f0d_next   = '{start: brk_reg, len: g_len[ADDR_W-1:0], used: 1'b1};
                        count_next = count_reg + ONE;
                    end
                end
            end
            S_FREE_DEC: begin
                if (released) begin
                    // nothing left allocated: back to an empty arena
                    used_next  = '0;
                    count_next = '0;
                    brk_next   = '0;
                    rrel_next  = 1'b1;
                end else begin
                    used_next  = used_reg - ONE;
                    two_next   = 1'b0;
                    count_next = count_reg - CW'(k);
                    up_next    = 1'b0;
                    dist_next  = CW'(k);
                    src_next   = shift_src;
                    stop_next  = count_reg - ONE;
                    if (mp) begin
                        f0a_next = idx_reg - ONE;
                        f0d_next = '{start: prev_reg.start,
                                     len: ADDR_W'(SUM_W'(prev_reg.len) + len_i + HDR),
                                     used: 1'b0};
                    end else begin
                        f0a_next = idx_reg;
                        f0d_next = '{start: cur_reg.start, len: len_i[ADDR_W-1:0],
                                     used: 1'b0};
                    end
                end
            end
            S_SHIFT_RD: begin
                ram_ra = src_reg;
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1;
                ram_wa = up_reg ? src_reg + ONE : src_reg - dist_reg;
                ram_wd = rd;
                src_next = up_reg ? src_reg - ONE : src_reg + ONE;
            end
            S_FIN0: begin
                ram_we = 1'b1;
                ram_wa = f0a_reg;
                ram_wd = f0d_reg;
            end
            S_FIN1: begin
                ram_we = 1'b1;
                ram_wa = f1a_reg;
                ram_wd = f1d_reg;
            end
            S_RESP: begin
                if (!ov_reg || out_ready) begin
                    ov_next  = 1'b1;
                    os_next  = rst_reg;
                    oa_next  = raddr_reg;
                    orl_next = rrel_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg   <= '0;
            used_reg  <= '0;
            chunk_reg <= CHUNK_RST;
            limit_reg <= LIMIT_RST;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
            used_reg  <= used_next;
            chunk_reg <= chunk_next;
            limit_reg <= limit_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        has_next_reg <= has_next_next;
        src_reg      <= src_next;
        stop_reg     <= stop_next;
        dist_reg     <= dist_next;
        up_reg       <= up_next;
        f0a_reg      <= f0a_next;
        f0d_reg      <= f0d_next;
        f1a_reg      <= f1a_next;
        f1d_reg      <= f1d_next;
        two_reg      <= two_next;
        rst_reg      <= rst_next;
        raddr_reg    <= raddr_next;
        rrel_reg     <= rrel_next;
        os_reg       <= os_next;
        oa_reg       <= oa_next;
        orl_reg      <= orl_next;
    end

    assign out_valid    = ov_reg;
    assign out_status   = os_reg;
    assign out_addr     = oa_reg;
    assign out_released = orl_reg;

endmodule

// File: hdl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// a request walks the descriptor table entry by entry, reading and then checking each;
//   a split or merge then moves entries up or down, reading and writing each one,
//   and the final descriptor writes and the result follow; walk and moves touch
//   disjoint parts of the table
// the back end takes one request at a time; a 2-word queue in front accepts until full
// reset: synchronous active-low aresetn empties the heap and restores register defaults
// at once; table contents are not cleared, as only entries below the count are read

module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_size, release_address, zero fill
    input  logic                 s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // payload_address, arena_released, zero fill
    output logic [1:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata
);

    logic              q_valid, q_ready;
    cmd_t              q_cmd;
    status_t           out_status;
    logic [ADDR_W-1:0] out_addr;
    logic              out_released;

    assign cfg_ready = 1'b1;

    ffha_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    ffha_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_idx_t'(cfg_index)),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_addr     (out_addr),
        .out_released (out_released)
    );

    assign m_tdata = {(M_TDATA_W - ADDR_W - 1)'(0), out_released, out_addr};
    assign m_tuser = out_status;

endmodule

// File: hdl/ffha_chk.sv
`timescale 1ns / 1ps
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffha_pkg

module ffha_chk import ffha_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("payload address on a failed request");

    a_release_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ADDR_W] |-> (m_tuser == ST_OK) && (m_tdata[ADDR_W-1:0] == '0))
        else $error("arena release with bad status or address");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
